@@ rtl/wpa_pkg.sv @@
`timescale 1ns / 1ps

package wpa_pkg;

	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_CHECK   = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_NOT_USED = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  entry_number;
		logic [31:0] watched_value;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  result_number;
		logic [31:0] previous_value;
		logic        changed;
	} out_beat_t;

	typedef struct packed {
		logic idle;
		logic done;
	} ctrl_sts_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ALLOC,
		ST_REL_NEXT,
		ST_REL_WALK,
		ST_REL_FREE,
		ST_CHECK,
		ST_DONE
	} st_t;

endpackage

@@ rtl/wpa_ram.sv @@
`timescale 1ns / 1ps

module wpa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/wpa_ctrl.sv @@
`timescale 1ns / 1ps

module wpa_ctrl import wpa_pkg::*; #(
	parameter int POOL_SIZE = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_beat_t  cmd,
	input  logic      take,
	output ctrl_sts_t sts,
	output out_beat_t res
);

	localparam int IDX_W  = $clog2(POOL_SIZE);
	localparam int LINK_W = $clog2(POOL_SIZE + 1);
	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(POOL_SIZE);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_SIZE - 1);

	st_t st_q, st_d;

	in_beat_t            cmd_q;
	out_beat_t           res_q, res_d;
	logic                res_load;
	logic [IDX_W-1:0]    idx_q, p_q, init_q;
	logic [LINK_W-1:0]   nidx_q, free_head_q, active_head_q;
	logic [POOL_SIZE-1:0] in_use_q;

	logic              l_we;
	logic [IDX_W-1:0]  l_waddr, l_raddr;
	logic [LINK_W-1:0] l_wdata, l_rdata;
	logic              v_we;
	logic [IDX_W-1:0]  v_waddr, v_raddr;
	logic [31:0]       v_wdata, v_rdata;

	logic             num_ok, num_used, free_ok, head_hit, walk_hit, walk_end, diff;
	logic [IDX_W-1:0] num_idx, fh_idx;

	wpa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_link (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	wpa_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_value (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	assign num_ok   = 32'(cmd.entry_number) < 32'(POOL_SIZE);
	assign num_idx  = IDX_W'(cmd.entry_number);
	assign num_used = num_ok && in_use_q[num_idx];
	assign free_ok  = free_head_q < NONE_LINK;
	assign fh_idx   = free_head_q[IDX_W-1:0];
	assign head_hit = active_head_q == LINK_W'(idx_q);
	assign walk_hit = l_rdata == LINK_W'(idx_q);
	assign walk_end = l_rdata >= NONE_LINK;
	assign diff     = v_rdata != cmd_q.watched_value;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_INIT: begin
				if (init_q == LAST_IDX) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (cmd.mode)
						MODE_ALLOC:   st_d = free_ok ? ST_ALLOC : ST_DONE;
						MODE_RELEASE: st_d = num_used ? ST_REL_NEXT : ST_DONE;
						MODE_CHECK:   st_d = num_used ? ST_CHECK : ST_DONE;
						default:      st_d = ST_DONE;
					endcase
				end
			end
			ST_ALLOC:    st_d = ST_DONE;
			ST_REL_NEXT: st_d = head_hit ? ST_REL_FREE : ST_REL_WALK;
			ST_REL_WALK: begin
				if (walk_hit || walk_end) st_d = ST_REL_FREE;
			end
			ST_REL_FREE: st_d = ST_DONE;
			ST_CHECK:    st_d = ST_DONE;
			ST_DONE: begin
				if (take) st_d = ST_IDLE;
			end
			default:     st_d = ST_INIT;
		endcase
	end

	always_comb begin
		l_we     = 1'b0;
		l_waddr  = idx_q;
		l_wdata  = free_head_q;
		l_raddr  = idx_q;
		v_we     = 1'b0;
		v_waddr  = idx_q;
		v_wdata  = cmd_q.watched_value;
		v_raddr  = idx_q;
		res_load = 1'b0;
		res_d    = '0;
		case (st_q)
			ST_INIT: begin
				l_we    = 1'b1;
				l_waddr = init_q;
				l_wdata = LINK_W'(init_q) + LINK_W'(1);
			end
			ST_IDLE: begin
				if (start) begin
					case (cmd.mode)
						MODE_ALLOC: begin
							l_raddr = fh_idx;
							v_we    = free_ok;
							v_waddr = fh_idx;
							v_wdata = cmd.watched_value;
							if (!free_ok) begin
								res_load     = 1'b1;
								res_d.status = STATUS_EMPTY;
							end
						end
						MODE_RELEASE, MODE_CHECK: begin
							l_raddr = num_idx;
							v_raddr = num_idx;
							if (!num_used) begin
								res_load            = 1'b1;
								res_d.status        = STATUS_NOT_USED;
								res_d.result_number = cmd.entry_number;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_ALLOC: begin
				l_we                = 1'b1;
				l_wdata             = active_head_q;
				res_load            = 1'b1;
				res_d.status        = STATUS_OK;
				res_d.result_number = 5'(idx_q);
			end
			ST_REL_NEXT: begin
				l_raddr = active_head_q[IDX_W-1:0];
			end
			ST_REL_WALK: begin
				l_raddr = l_rdata[IDX_W-1:0];
				if (walk_hit) begin
					l_we    = 1'b1;
					l_waddr = p_q;
					l_wdata = nidx_q;
				end
			end
			ST_REL_FREE: begin
				l_we                = 1'b1;
				res_load            = 1'b1;
				res_d.status        = STATUS_OK;
				res_d.result_number = cmd_q.entry_number;
			end
			ST_CHECK: begin
				v_we                 = diff;
				res_load             = 1'b1;
				res_d.status         = STATUS_OK;
				res_d.result_number  = cmd_q.entry_number;
				res_d.previous_value = v_rdata;
				res_d.changed        = diff;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_INIT;
			init_q        <= '0;
			free_head_q   <= '0;
			active_head_q <= NONE_LINK;
			in_use_q      <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_INIT: begin
					init_q <= init_q + IDX_W'(1);
				end
				ST_ALLOC: begin
					free_head_q     <= l_rdata;
					active_head_q   <= LINK_W'(idx_q);
					in_use_q[idx_q] <= 1'b1;
				end
				ST_REL_NEXT: begin
					if (head_hit) active_head_q <= l_rdata;
				end
				ST_REL_FREE: begin
					free_head_q     <= LINK_W'(idx_q);
					in_use_q[idx_q] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd;
			idx_q <= (cmd.mode == MODE_ALLOC) ? fh_idx : num_idx;
		end
		if (st_q == ST_REL_NEXT) begin
			nidx_q <= l_rdata;
			p_q    <= active_head_q[IDX_W-1:0];
		end
		if (st_q == ST_REL_WALK) begin
			p_q <= l_rdata[IDX_W-1:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign sts.idle = st_q == ST_IDLE;
	assign sts.done = st_q == ST_DONE;
	assign res      = res_q;

endmodule

@@ rtl/watchpoint_pool_allocator_core.sv @@
// channel | direction | payload    | handshake
// in      | input     | in_beat_t  | in_valid / in_ready
// out     | output    | out_beat_t | out_valid / out_ready
//
// Allocate and check pass ST_ALLOC or ST_CHECK to ST_DONE, a rejected beat goes
// straight to ST_DONE. Release walks to the predecessor in ST_REL_WALK unless the
// entry heads the active list, reading one link a cycle from the link memory.
// After reset the link memory is initialised entry by entry, in_ready low.
// One beat is worked at a time; the next is taken while a result waits in the
// output register, and the block holds only if that register is still full.
`timescale 1ns / 1ps

module watchpoint_pool_allocator_core import wpa_pkg::*; #(
	parameter int POOL_SIZE = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	ctrl_sts_t sts;
	out_beat_t res;
	logic      start, take;
	logic      out_valid_q;
	out_beat_t out_q;

	assign in_ready = sts.idle;
	assign start    = in_valid && in_ready;
	assign take     = sts.done && (!out_valid_q || out_ready);

	wpa_ctrl #(.POOL_SIZE(POOL_SIZE)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (in_data),
		.take   (take),
		.sts    (sts),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/wpa_checker.sv @@
`timescale 1ns / 1ps

module wpa_checker import wpa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_beat_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);

	// one beat at a time: ready drops after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready held after a beat was taken");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STATUS_OK
			|-> out_data.previous_value == 32'd0 && !out_data.changed)
		else $error("failed beat carries check data");

	a_empty_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STATUS_EMPTY |-> out_data.result_number == 5'd0)
		else $error("empty pool result carries an entry number");

endmodule

bind watchpoint_pool_allocator_core wpa_checker u_wpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import wpa_pkg::*;

	localparam int POOL = 32;
	localparam int NO_LINK = POOL;
	localparam int STALL_LIMIT = 4000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int BEATS_PER_PHASE = 530;
	localparam int EPOCH = 150;
	localparam int TAIL_CYCLES = 64;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	class entry_ledger;
		int link_of[POOL];
		int free_head;
		int active_head;
		bit busy[POOL];
		logic [31:0] held[POOL];
		out_beat_t due[$];
		int errors;

		function new();
			for (int i = 0; i < POOL; i++) begin
				link_of[i] = i + 1;
				busy[i] = 1'b0;
				held[i] = '0;
			end
			free_head = 0;
			active_head = NO_LINK;
			errors = 0;
		endfunction

		function void note_beat(in_beat_t b);
			out_beat_t r;
			int n;
			int p;
			int steps;
			bit found;
			r = '0;
			n = int'(b.entry_number);
			case (b.mode)
			MODE_ALLOC: begin
				if (free_head >= POOL) begin
					r.status = STATUS_EMPTY;
				end else begin
					p = free_head;
					free_head = link_of[p];
					link_of[p] = active_head;
					active_head = p;
					busy[p] = 1'b1;
					held[p] = b.watched_value;
					r.result_number = p[4:0];
				end
			end
			MODE_RELEASE: begin
				r.result_number = b.entry_number;
				if (!busy[n]) begin
					r.status = STATUS_NOT_USED;
				end else begin
					if (active_head == n) begin
						active_head = link_of[n];
					end else begin
						// walk for the predecessor
						p = active_head;
						steps = 0;
						found = 1'b0;
						while (!found && steps < POOL && p < POOL) begin
							if (link_of[p] == n) begin
								link_of[p] = link_of[n];
								found = 1'b1;
							end else begin
								p = link_of[p];
							end
							steps++;
						end
					end
					link_of[n] = free_head;
					free_head = n;
					busy[n] = 1'b0;
				end
			end
			MODE_CHECK: begin
				r.result_number = b.entry_number;
				if (!busy[n]) begin
					r.status = STATUS_NOT_USED;
				end else begin
					r.previous_value = held[n];
					if (held[n] != b.watched_value) begin
						held[n] = b.watched_value;
						r.changed = 1'b1;
					end
				end
			end
			default: begin
			end
			endcase
			due.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("%0t: %s", $time, msg);
		endtask

		task check_beat(out_beat_t got);
			out_beat_t want;
			if (due.size() == 0) begin
				report($sformatf("result beat with none due: st %0d num %0d prev %h chg %b",
					got.status, got.result_number, got.previous_value, got.changed));
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.result_number !== want.result_number)
				report($sformatf("result_number %0d, want %0d",
					got.result_number, want.result_number));
			if (got.previous_value !== want.previous_value)
				report($sformatf("previous_value %h, want %h",
					got.previous_value, want.previous_value));
			if (got.changed !== want.changed)
				report($sformatf("changed %b, want %b", got.changed, want.changed));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_beat_t out_data;

	entry_ledger ledger = new();
	int tx_idle = 32;
	int rx_idle = 78;
	bit squeeze = 1'b0;
	int quiet = 0;

	watchpoint_pool_allocator_core #(
		.POOL_SIZE(POOL)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_beat(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver; a long hold-off lets the block fill and stall its input
	initial begin
		forever begin
			@(posedge clk);
			if (squeeze) begin
				squeeze = 1'b0;
				out_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_beat(input in_beat_t b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		ledger.note_beat(b);
	endtask

	task automatic offer(input logic [1:0] m, input logic [4:0] n, input logic [31:0] v);
		in_beat_t b;
		b.mode = m;
		b.entry_number = n;
		b.watched_value = v;
		send_beat(b);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
		0: return '0;
		1: return '1;
		default: return $urandom;
		endcase
	endfunction

	// mostly well-formed traffic on live entries; filling epochs drive the pool empty
	function automatic in_beat_t pick_beat(bit filling);
		in_beat_t b;
		int r;
		int live[$];
		r = $urandom_range(99);
		for (int i = 0; i < POOL; i++)
			if (ledger.busy[i])
				live.push_back(i);
		b.mode = MODE_ALLOC;
		b.entry_number = 5'($urandom);
		b.watched_value = pick_word();
		if (r < 8) begin
			b.mode = 2'($urandom_range(3));
		end else if (r >= (filling ? 58 : 20) && live.size() > 0) begin
			b.entry_number = 5'(live[$urandom_range(live.size() - 1)]);
			if (r < (filling ? 74 : 65)) begin
				b.mode = MODE_RELEASE;
			end else begin
				b.mode = MODE_CHECK;
				if ($urandom_range(1))
					b.watched_value = ledger.held[b.entry_number];
			end
		end
		return b;
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(MODE_CHECK, 5'd0, 32'h0);
		offer(MODE_RELEASE, 5'd31, 32'hFFFF_FFFF);
		offer(MODE_ALLOC, 5'd31, 32'h0000_0000);
		offer(MODE_ALLOC, 5'd0, 32'hFFFF_FFFF);
		offer(MODE_ALLOC, 5'd7, 32'hA5A5_A5A5);
		offer(MODE_ALLOC, 5'd24, 32'h5A5A_5A5A);
		offer(MODE_CHECK, 5'd0, 32'h0000_0000);
		offer(MODE_CHECK, 5'd1, 32'h0000_0000);
		offer(MODE_CHECK, 5'd1, 32'hFFFF_FFFF);
		offer(MODE_CHECK, 5'd2, 32'hA5A5_A5A5);
		offer(MODE_SPARE, 5'd31, 32'hFFFF_FFFF);
		offer(MODE_RELEASE, 5'd1, 32'h0);
		offer(MODE_RELEASE, 5'd3, 32'h0);
		offer(MODE_RELEASE, 5'd0, 32'h0);
		offer(MODE_RELEASE, 5'd0, 32'h0);
		offer(MODE_CHECK, 5'd3, 32'h5A5A_5A5A);
		offer(MODE_ALLOC, 5'd0, 32'h1234_5678);
		offer(MODE_CHECK, 5'd31, 32'hFFFF_FFFF);
		offer(MODE_RELEASE, 5'd2, 32'h0);
		offer(MODE_RELEASE, 5'd0, 32'h0);

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				tx_idle = 78;
				rx_idle = 32;
			end
			if (ph == 2) begin
				tx_idle = 0;
				rx_idle = 0;
				squeeze = 1'b1;
			end
			for (int k = 0; k < BEATS_PER_PHASE; k++)
				send_beat(pick_beat(((k / EPOCH) % 2) == 0));
		end
		in_valid <= 1'b0;

		while (ledger.due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ledger.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
